@@ hdl/sbc_pkg.sv @@
// shared types and constants for the serial bcd up/down counter
// no dependencies; every other file in hdl/ refers to this package by scoped names

package sbc_pkg;

    // widest digit count the job format can carry
    localparam int MAX_DIGITS   = 8;
    localparam int DIGIT_SEL_W  = $clog2(MAX_DIGITS);

    localparam logic [3:0]  DIGIT_MAX   = 4'd9;
    localparam logic [15:0] BLINK_RESET = 16'd10000;

    // item kinds on the input channel
    localparam logic CMD_RX_BYTE = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    // received command bytes
    localparam logic [7:0] BYTE_UP          = 8'h31;
    localparam logic [7:0] BYTE_UP_REPEAT   = 8'h32;
    localparam logic [7:0] BYTE_DOWN        = 8'h34;
    localparam logic [7:0] BYTE_DOWN_REPEAT = 8'h35;
    localparam logic [7:0] BYTE_QUERY       = 8'h36;

    // transmitted characters
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_ONE  = 8'h31;
    localparam logic [7:0] ASCII_A    = 8'h41;
    localparam logic [7:0] ASCII_F    = 8'h46;
    localparam logic [7:0] ASCII_R    = 8'h52;

    // register byte addresses
    localparam logic REG_BLINK_LIMIT = 1'b0;

    typedef enum logic [2:0] {
        MODE_STOP        = 3'd0,
        MODE_UP          = 3'd1,
        MODE_UP_REPEAT   = 3'd2,
        MODE_DOWN        = 3'd3,
        MODE_DOWN_REPEAT = 3'd4,
        MODE_QUERY       = 3'd5
    } t_mode;

    // what the back end has to send for one accepted item
    typedef enum logic [1:0] {
        KIND_SILENT = 2'd0,
        KIND_QUERY  = 2'd1,
        KIND_DIGITS = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                       kind;
        logic                        led;
        logic                        foot;
        logic [MAX_DIGITS-1:0][3:0]  digits;
    } t_job;

endpackage

@@ hdl/serial_bcd_updown_counter.sv @@
// top level of the serial bcd up/down counter: register port, front end, job queue, back end
// depends on sbc_pkg, sbc_front, sbc_fifo and sbc_back
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------------
//  input    | in        | i_valid / o_stall  | i_command, i_rx_byte
//  result   | out       | o_valid / i_stall  | o_tx_valid, o_tx_byte, o_led_on, o_last
//  register | in        | psel/penable/pready| paddr, pwrite, pwdata, prdata
//
//  an input beat is classified and applied in its accept cycle and leaves a job in a
//  two-entry queue; the back end sends 1 beat for a byte or a stopped tick, 2 for a
//  query and 2*DIGIT_COUNT for a step, one beat per cycle while i_stall is low, from
//  its single result port
//  reset is synchronous and active low; no clearing pass, ready once reset is released
//  o_stall rises only when the queue is full; i_stall holds the current beat steady

module serial_bcd_updown_counter #(
    parameter int DIGIT_COUNT = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [7:0]  i_rx_byte,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic        o_led_on,
    output logic        o_last,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]   r_blink_limit;
    logic          in_accept;
    logic          reg_write;
    // job handed from front end to queue, and from queue to back end
    sbc_pkg::t_job front_job;
    sbc_pkg::t_job queue_job;
    logic          queue_empty;
    logic          queue_full;
    logic          queue_pop;

    // register port: one register, always ready
    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == sbc_pkg::REG_BLINK_LIMIT) ? {16'd0, r_blink_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_limit <= sbc_pkg::BLINK_RESET;
        end else if (reg_write && (paddr[2] == sbc_pkg::REG_BLINK_LIMIT)) begin
            r_blink_limit <= pwdata[15:0];
        end
    end

    // input side only waits on a full queue
    assign o_stall   = queue_full;
    assign in_accept = i_valid && !queue_full;

    sbc_front #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_command     (i_command),
        .i_rx_byte     (i_rx_byte),
        .i_blink_limit (r_blink_limit),
        .o_job         (front_job)
    );

    sbc_fifo #(
        .DEPTH (2)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  (front_job),
        .i_pop   (queue_pop),
        .o_data  (queue_job),
        .o_empty (queue_empty),
        .o_full  (queue_full)
    );

    sbc_back #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (queue_job),
        .i_empty    (queue_empty),
        .o_pop      (queue_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_tx_valid (o_tx_valid),
        .o_tx_byte  (o_tx_byte),
        .o_led_on   (o_led_on),
        .o_last     (o_last)
    );

    // a run of beats continues without a gap until its last beat
    a_run_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=> o_valid)
        else $error("result run broke before its last beat");

    // a beat with nothing to send is always a run of its own
    a_silent_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_tx_valid |-> o_last)
        else $error("silent beat not marked last");

    // any digit character sent is a decimal digit
    a_digit_bcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_tx_valid && (o_tx_byte[7:4] == 4'h3) |-> (o_tx_byte[3:0] <= 4'd9))
        else $error("digit character out of decimal range");

    // the led level stays the same across the beats of one run
    a_led_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=> $stable(o_led_on))
        else $error("led level changed inside a run");

endmodule

@@ hdl/sbc_front.sv @@
// front end: accepts items, keeps counter, mode and blink state, builds one job per item
// depends on sbc_pkg

module sbc_front #(
    parameter int DIGIT_COUNT = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_command,
    input  logic [7:0]    i_rx_byte,
    input  logic [15:0]   i_blink_limit,
    output sbc_pkg::t_job o_job
);

    logic [DIGIT_COUNT-1:0][3:0] r_digits, n_digits;
    logic [DIGIT_COUNT-1:0][3:0] inc_digits, dec_digits;
    sbc_pkg::t_mode              r_mode, n_mode;
    logic [15:0]                 r_tick, n_tick, tick_inc;
    logic                        r_foot, n_foot;
    logic                        r_led, n_led;
    logic                        all_nine, all_zero, carry, borrow;
    logic                        wrap;

    // saturating bcd increment and decrement, ripple over the digits
    always_comb begin
        all_nine   = 1'b1;
        all_zero   = 1'b1;
        carry      = 1'b1;
        borrow     = 1'b1;
        inc_digits = r_digits;
        dec_digits = r_digits;
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            all_nine = all_nine & (r_digits[i] == sbc_pkg::DIGIT_MAX);
            all_zero = all_zero & (r_digits[i] == 4'd0);
            if (carry) begin
                if (r_digits[i] < sbc_pkg::DIGIT_MAX) begin
                    inc_digits[i] = r_digits[i] + 4'd1;
                    carry         = 1'b0;
                end else begin
                    inc_digits[i] = 4'd0;
                end
            end
            if (borrow) begin
                if (r_digits[i] != 4'd0) begin
                    dec_digits[i] = r_digits[i] - 4'd1;
                    borrow        = 1'b0;
                end else begin
                    dec_digits[i] = sbc_pkg::DIGIT_MAX;
                end
            end
        end
        if (all_nine) begin
            inc_digits = r_digits;
        end
        if (all_zero) begin
            dec_digits = r_digits;
        end
    end

    assign tick_inc = r_tick + 16'd1;
    assign wrap     = (tick_inc > i_blink_limit);

    always_comb begin
        n_digits = r_digits;
        n_mode   = r_mode;
        n_tick   = r_tick;
        n_foot   = r_foot;
        n_led    = r_led;
        o_job.kind = sbc_pkg::KIND_SILENT;
        if (i_command == sbc_pkg::CMD_TICK) begin
            n_tick = wrap ? 16'd0 : tick_inc;
            n_led  = wrap ? r_foot : r_led;
            n_foot = r_foot ^ wrap;
            case (r_mode)
                sbc_pkg::MODE_UP, sbc_pkg::MODE_UP_REPEAT: begin
                    n_digits   = inc_digits;
                    n_mode     = (r_mode == sbc_pkg::MODE_UP) ? sbc_pkg::MODE_STOP : r_mode;
                    o_job.kind = sbc_pkg::KIND_DIGITS;
                end
                sbc_pkg::MODE_DOWN, sbc_pkg::MODE_DOWN_REPEAT: begin
                    n_digits   = dec_digits;
                    n_mode     = (r_mode == sbc_pkg::MODE_DOWN) ? sbc_pkg::MODE_STOP : r_mode;
                    o_job.kind = sbc_pkg::KIND_DIGITS;
                end
                sbc_pkg::MODE_QUERY: begin
                    n_mode     = sbc_pkg::MODE_STOP;
                    o_job.kind = sbc_pkg::KIND_QUERY;
                end
                default: begin
                    n_mode = sbc_pkg::MODE_STOP;
                end
            endcase
        end else begin
            case (i_rx_byte)
                sbc_pkg::BYTE_UP:          n_mode = sbc_pkg::MODE_UP;
                sbc_pkg::BYTE_UP_REPEAT:   n_mode = sbc_pkg::MODE_UP_REPEAT;
                sbc_pkg::BYTE_DOWN:        n_mode = sbc_pkg::MODE_DOWN;
                sbc_pkg::BYTE_DOWN_REPEAT: n_mode = sbc_pkg::MODE_DOWN_REPEAT;
                sbc_pkg::BYTE_QUERY:       n_mode = sbc_pkg::MODE_QUERY;
                default:                   n_mode = sbc_pkg::MODE_STOP;
            endcase
        end
        o_job.led    = n_led;
        o_job.foot   = n_foot;
        o_job.digits = '0;
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            o_job.digits[i] = n_digits[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                r_digits[i] <= (i < 3) ? 4'(i + 1) : 4'd0;
            end
            r_mode <= sbc_pkg::MODE_STOP;
            r_tick <= 16'd0;
            r_foot <= 1'b0;
            r_led  <= 1'b0;
        end else if (i_accept) begin
            r_digits <= n_digits;
            r_mode   <= n_mode;
            r_tick   <= n_tick;
            r_foot   <= n_foot;
            r_led    <= n_led;
        end
    end

endmodule

@@ hdl/sbc_fifo.sv @@
// short job queue between front and back end
// depends on sbc_pkg for the job type

module sbc_fifo #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sbc_pkg::t_job i_data,
    input  logic          i_pop,
    output sbc_pkg::t_job o_data,
    output logic          o_empty,
    output logic          o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sbc_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_empty = (r_count == CW'(0));
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

@@ hdl/sbc_back.sv @@
// back end: takes one job from the queue and sends its result beats one per cycle
// while i_stall is low; depends on sbc_pkg

module sbc_back #(
    parameter int DIGIT_COUNT = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sbc_pkg::t_job i_job,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic          o_tx_valid,
    output logic [7:0]    o_tx_byte,
    output logic          o_led_on,
    output logic          o_last
);

    localparam int IW = $clog2(2 * DIGIT_COUNT);

    sbc_pkg::t_job                   r_job;
    logic                            r_busy;
    logic [IW-1:0]                   r_idx;
    logic [sbc_pkg::DIGIT_SEL_W-1:0] dsel;
    logic                            beat_done;

    assign dsel      = sbc_pkg::DIGIT_SEL_W'(r_idx >> 1);
    assign beat_done = r_busy && !i_stall;
    // next job loads when idle or as the last beat of the current one leaves
    assign o_pop     = !i_empty && (!r_busy || (beat_done && o_last));

    always_comb begin
        o_tx_byte = 8'd0;
        case (r_job.kind)
            sbc_pkg::KIND_DIGITS: begin
                o_last = (r_idx == IW'(2 * DIGIT_COUNT - 1));
                if (!r_idx[0]) begin
                    o_tx_byte = sbc_pkg::ASCII_A + 8'(dsel);
                end else begin
                    o_tx_byte = sbc_pkg::ASCII_ZERO + {4'd0, r_job.digits[dsel]};
                end
            end
            sbc_pkg::KIND_QUERY: begin
                o_last = (r_idx == IW'(1));
                if (r_idx == IW'(0)) begin
                    o_tx_byte = r_job.foot ? sbc_pkg::ASCII_R : sbc_pkg::ASCII_F;
                end else begin
                    o_tx_byte = sbc_pkg::ASCII_ONE;
                end
            end
            default: begin
                o_last = 1'b1;
            end
        endcase
    end

    assign o_valid    = r_busy;
    assign o_tx_valid = (r_job.kind != sbc_pkg::KIND_SILENT);
    assign o_led_on   = r_job.led;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (beat_done) begin
            if (o_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + IW'(1);
            end
        end
    end

endmodule
